// ----- sv/easing_curve_evaluator_top_macros.svh -----
// Assertion macros shared by the easing curve evaluator RTL.
`ifndef EASING_CURVE_EVALUATOR_TOP_MACROS_SVH
`define EASING_CURVE_EVALUATOR_TOP_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold from the same edge on.
`define ECE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ECE_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ----- sv/ece_pkg.sv -----
// Package with the curve codes and fixed-point constants of the easing curve evaluator.
`default_nettype none

package ece_pkg;

   typedef enum logic [2:0] {
      CurveLinear    = 3'd0,
      CurveEaseIn    = 3'd1,
      CurveEaseOut   = 3'd2,
      CurveEaseInOut = 3'd3,
      CurveBounce    = 3'd4,
      CurveBack      = 3'd5
   } curve_type;

   localparam logic [15:0] QOne     = 16'd32768;
   localparam logic [15:0] QHalf    = 16'd16384;
   localparam logic [15:0] EasedMax = 16'd40960;

   // Bounce curve: 7.5625 in Q.15, segment bounds, centers and offsets.
   localparam logic [17:0] BounceN1 = 18'd247808;
   localparam logic [15:0] BounceT1 = 16'd11916;
   localparam logic [15:0] BounceT2 = 16'd23831;
   localparam logic [15:0] BounceT3 = 16'd29789;
   localparam logic [15:0] BounceC2 = 16'd17873;
   localparam logic [15:0] BounceC3 = 16'd26810;
   localparam logic [15:0] BounceC4 = 16'd31279;
   localparam logic [15:0] BounceK2 = 16'd24576;
   localparam logic [15:0] BounceK3 = 16'd30720;
   localparam logic [15:0] BounceK4 = 16'd32256;

   // Back overshoot: c1 = 1.70158 and c3 = c1 + 1, both in Q.15.
   localparam logic [16:0] BackC1 = 17'd55757;
   localparam logic [16:0] BackC3 = 17'd88525;

endpackage

`default_nettype wire

// ----- sv/ece_back.sv -----
// Back overshoot tail: cube term, both constant products and the final difference.
`default_nettype none

module ece_back (
   input  wire logic               clock,
   input  wire logic [16:0]        u2,
   input  wire logic [15:0]        b,
   output logic signed [18:0]      back_val
);
   import ece_pkg::*;

   logic [33:0] u3p_ff, u3p_in;
   logic [33:0] pp_ff, pp_in;
   logic [16:0] u3_ff, u3_in;
   logic [16:0] p5_ff, p5_in;
   logic [34:0] q_ff, q_in;
   logic [16:0] p6_ff;
   logic [34:0] u3_rnd;
   logic [34:0] p_rnd;
   logic [35:0] q_rnd;
   logic [16:0] q_r;

   always_comb begin
      u3p_in = 34'(u2) * 34'(b);
      pp_in  = 34'(BackC1) * 34'(u2);
      u3_rnd = 35'(u3p_ff) + 35'(16384);
      p_rnd  = 35'(pp_ff) + 35'(16384);
      u3_in  = u3_rnd[31:15];
      p5_in  = p_rnd[31:15];
      q_in   = 35'(BackC3) * 35'(u3_ff);
   end

   always_ff @(posedge clock) begin
      u3p_ff <= u3p_in;
      pp_ff  <= pp_in;
      u3_ff  <= u3_in;
      p5_ff  <= p5_in;
      q_ff   <= q_in;
      p6_ff  <= p5_ff;
   end

   // The rounded cube product never exceeds c3, so 17 bits hold it.
   always_comb begin
      q_rnd    = 36'(q_ff) + 36'(16384);
      q_r      = q_rnd[31:15];
      back_val = $signed(19'(QOne)) + $signed({2'b00, p6_ff}) - $signed({2'b00, q_r});
   end

endmodule

`default_nettype wire

// ----- sv/easing_curve_evaluator_top.sv -----
// Top level of the easing curve evaluator: a seven-stage pipeline from progress word to eased word.
`default_nettype none

// The block takes one progress word per clock and never asserts busy. Each word
// accepted with start comes back on rsp_eased with rsp_strobe once it has passed
// every pipeline stage, in order; the strobe lasts one cycle and is not held. The
// latency is set by the chain of products in the back overshoot curve (square,
// cube, constant product, each followed by a register); every other curve
// travels the same stages so that all results keep a fixed latency.
module easing_curve_evaluator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_alpha,
   input  wire logic [2:0]  req_curve_select,
   output logic             rsp_strobe,
   output logic [15:0]      rsp_eased
);
   import ece_pkg::*;
   `include "easing_curve_evaluator_top_macros.svh"

   logic        accept;
   logic [6:0]  vld_ff, vld_in;

   // Stage 1: clamp and operand selection.
   logic [15:0] a_c, b_c;
   logic [15:0] a1_ff, a1_in, b1_ff, b1_in, op1_ff, op1_in, off1_ff, off1_in;
   logic        lo1_ff, lo1_in;
   curve_type   sel1_ff, sel1_in;

   // Stage 2: square.
   logic [15:0] a2_ff, b2_ff, off2_ff;
   logic        lo2_ff;
   curve_type   sel2_ff;
   logic [31:0] sq2_ff, sq2_in;

   // Stage 3: rounding of the square and bounce product.
   logic [32:0] rnd15, rnd14;
   logic [16:0] r15;
   logic [16:0] r14;
   logic [16:0] val3_ff, val3_in;
   logic [45:0] bp3_ff, bp3_in;
   logic [16:0] u2_3_ff;
   logic [15:0] b3_ff, off3_ff;
   curve_type   sel3_ff;

   // Stages 4 to 6: bounce result, then the value waits for the back tail.
   logic [46:0] bp_rnd;
   logic [16:0] val4_ff, val4_in, val5_ff, val6_ff;
   curve_type   sel4_ff, sel5_ff, sel6_ff;

   // Stage 7: selection and saturation.
   logic signed [18:0] back_val;
   logic signed [18:0] res;
   logic [15:0]        eased_ff, eased_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[5:0], accept};

   always_comb begin
      a_c     = (req_alpha > QOne) ? QOne : req_alpha;
      b_c     = QOne - a_c;
      a1_in   = a_c;
      b1_in   = b_c;
      sel1_in = curve_type'(req_curve_select);
      lo1_in  = a_c < QHalf;
      op1_in  = '0;
      off1_in = '0;
      unique case (sel1_in) inside
         CurveEaseIn: op1_in = a_c;
         CurveEaseOut, CurveBack: op1_in = b_c;
         CurveEaseInOut: op1_in = lo1_in ? a_c : b_c;
         CurveBounce: begin
            if (a_c < BounceT1) begin
               op1_in = a_c;
            end else if (a_c < BounceT2) begin
               op1_in  = (a_c >= BounceC2) ? a_c - BounceC2 : BounceC2 - a_c;
               off1_in = BounceK2;
            end else if (a_c < BounceT3) begin
               op1_in  = (a_c >= BounceC3) ? a_c - BounceC3 : BounceC3 - a_c;
               off1_in = BounceK3;
            end else begin
               op1_in  = (a_c >= BounceC4) ? a_c - BounceC4 : BounceC4 - a_c;
               off1_in = BounceK4;
            end
         end
         default: op1_in = '0;
      endcase
   end

   assign sq2_in = 32'(op1_ff) * 32'(op1_ff);

   // Operands never exceed one, so the square stays within 2^30.
   always_comb begin
      rnd15   = 33'(sq2_ff) + 33'(16384);
      rnd14   = 33'(sq2_ff) + 33'(8192);
      r15     = rnd15[31:15];
      r14     = rnd14[30:14];
      bp3_in  = 46'(BounceN1) * 46'(sq2_ff[27:0]);
      case (sel2_ff)
         CurveEaseIn:    val3_in = r15;
         CurveEaseOut:   val3_in = 17'(QOne) - r15;
         CurveEaseInOut: val3_in = lo2_ff ? r14 : 17'(QOne) - r14;
         default:        val3_in = 17'(a2_ff);
      endcase
   end

   always_comb begin
      bp_rnd  = 47'(bp3_ff) + 47'(30'h2000_0000);
      val4_in = (sel3_ff == CurveBounce) ? bp_rnd[46:30] + 17'(off3_ff) : val3_ff;
   end

   ece_back u_back (
      .clock    (clock),
      .u2       (u2_3_ff),
      .b        (b3_ff),
      .back_val (back_val)
   );

   always_comb begin
      res = (sel6_ff == CurveBack) ? back_val : $signed({2'b00, val6_ff});
      if (res < 0) begin
         eased_in = '0;
      end else if (res > $signed(19'(EasedMax))) begin
         eased_in = EasedMax;
      end else begin
         eased_in = res[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff    <= a1_in;
      b1_ff    <= b1_in;
      op1_ff   <= op1_in;
      off1_ff  <= off1_in;
      lo1_ff   <= lo1_in;
      sel1_ff  <= sel1_in;
      a2_ff    <= a1_ff;
      b2_ff    <= b1_ff;
      off2_ff  <= off1_ff;
      lo2_ff   <= lo1_ff;
      sel2_ff  <= sel1_ff;
      sq2_ff   <= sq2_in;
      val3_ff  <= val3_in;
      bp3_ff   <= bp3_in;
      u2_3_ff  <= r15;
      b3_ff    <= b2_ff;
      off3_ff  <= off2_ff;
      sel3_ff  <= sel2_ff;
      val4_ff  <= val4_in;
      sel4_ff  <= sel3_ff;
      val5_ff  <= val4_ff;
      sel5_ff  <= sel4_ff;
      val6_ff  <= val5_ff;
      sel6_ff  <= sel5_ff;
      eased_ff <= eased_in;
   end

   assign rsp_strobe = vld_ff[6];
   assign rsp_eased  = eased_ff;

   `ECE_ASSERT_NEVER(a_eased_range, rsp_strobe && (rsp_eased > EasedMax),
      "eased word above 1.25")
   `ECE_ASSERT_IMPLIES(a_latency, start, ##7 rsp_strobe,
      "accepted word did not return after seven cycles")
   `ECE_ASSERT_IMPLIES(a_linear_identity,
      rsp_strobe && $past(start && (req_curve_select == CurveLinear) && (req_alpha <= QOne), 7),
      rsp_eased == $past(req_alpha, 7), "linear curve changed the progress word")
   `ECE_ASSERT_IMPLIES(a_quad_endpoint,
      rsp_strobe && $past(start && (req_alpha >= QOne) && ((req_curve_select == CurveEaseIn)
         || (req_curve_select == CurveEaseOut) || (req_curve_select == CurveEaseInOut)), 7),
      rsp_eased == QOne, "quadratic curve missed one at full progress")

endmodule

`default_nettype wire

// ----- tb/easing_curve_evaluator_top_tb.sv -----
// Self-checking testbench for the easing curve evaluator with a built-in predictor of every curve.
`default_nettype none

module easing_curve_evaluator_top_tb;
   import ece_pkg::*;

   typedef struct packed {
      logic [15:0] alpha;
      logic [2:0]  curve;
   } progress_word_type;

   typedef struct packed {
      logic [15:0] alpha;
      logic [2:0]  curve;
      logic [15:0] eased;
   } eased_entry_type;

   localparam int RandomWords = 650;
   localparam int QuietTail   = 100;
   localparam int StallLimit  = 200;
   localparam int DrainCycles = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [15:0] req_alpha = '0;
   logic [2:0]  req_curve_select = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [15:0] rsp_eased;

   progress_word_type pending_words[$];
   eased_entry_type   eased_due[$];
   int                fault_count = 0;
   int                gap_left = 0;
   bit                calm = 1'b0;
   int                idle_cycles = 0;

   easing_curve_evaluator_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_alpha        (req_alpha),
      .req_curve_select (req_curve_select),
      .rsp_strobe       (rsp_strobe),
      .rsp_eased        (rsp_eased)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint round_shr(input longint v, input int unsigned sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic logic [15:0] eased_value(input logic [15:0] alpha, input logic [2:0] sel);
      longint one, a, b, d, u2, u3, r;
      one = longint'(QOne);
      a = (alpha > QOne) ? one : longint'(alpha);
      b = one - a;
      case (sel)
         CurveEaseIn: begin
            r = round_shr(a * a, 15);
         end
         CurveEaseOut: begin
            r = one - round_shr(b * b, 15);
         end
         CurveEaseInOut: begin
            if (a < longint'(QHalf)) begin
               r = round_shr(a * a, 14);
            end else begin
               r = one - round_shr(b * b, 14);
            end
         end
         CurveBounce: begin
            // Each segment is a parabola around its center, lifted by its offset.
            if (a < longint'(BounceT1)) begin
               d = a;
               r = 0;
            end else if (a < longint'(BounceT2)) begin
               d = a - longint'(BounceC2);
               r = longint'(BounceK2);
            end else if (a < longint'(BounceT3)) begin
               d = a - longint'(BounceC3);
               r = longint'(BounceK3);
            end else begin
               d = a - longint'(BounceC4);
               r = longint'(BounceK4);
            end
            r = r + round_shr(longint'(BounceN1) * d * d, 30);
         end
         CurveBack: begin
            u2 = round_shr(b * b, 15);
            u3 = round_shr(u2 * b, 15);
            r = one + round_shr(longint'(BackC1) * u2, 15)
                    - round_shr(longint'(BackC3) * u3, 15);
         end
         default: begin
            r = a;
         end
      endcase
      if (r < 0) r = 0;
      if (r > longint'(EasedMax)) r = longint'(EasedMax);
      return r[15:0];
   endfunction

   // Driver: offers the oldest pending word and predicts its result once it is taken.
   always @(posedge clock) begin
      progress_word_type sent;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            sent = pending_words.pop_front();
            eased_due.push_back({sent.alpha, sent.curve, eased_value(sent.alpha, sent.curve)});
            if ($urandom_range(0, 39) == 0) calm = !calm;
            if (!calm && pending_words.size() > QuietTail && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 18);
         end
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (pending_words.size() != 0) begin
            start <= 1'b1;
            req_alpha <= pending_words[0].alpha;
            req_curve_select <= pending_words[0].curve;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed word must match the oldest prediction.
   always @(posedge clock) begin
      eased_entry_type want;
      if (!reset && rsp_strobe) begin
         if (eased_due.size() == 0) begin
            fault_count = fault_count + 1;
            if (fault_count <= 10)
               $display("unexpected result word: eased=%0d", rsp_eased);
         end else begin
            want = eased_due.pop_front();
            if (rsp_eased !== want.eased) begin
               fault_count = fault_count + 1;
               if (fault_count <= 10)
                  $display("mismatch: alpha=%0d curve=%0d expected eased=%0d actual=%0d",
                           want.alpha, want.curve, want.eased, rsp_eased);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("easing_curve_evaluator_top_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [15:0] marks[6];
      logic [15:0] alpha;
      int          pick;
      marks[0] = 16'd0;
      marks[1] = BounceT1;
      marks[2] = QHalf;
      marks[3] = BounceT2;
      marks[4] = BounceT3;
      marks[5] = QOne;

      // Every selector at both ends of the alpha field.
      for (int s = 0; s < 8; s++) begin
         pending_words.push_back({16'd0, 3'(s)});
         pending_words.push_back({16'hFFFF, 3'(s)});
      end
      pending_words.push_back({QOne, 3'(CurveBack)});
      pending_words.push_back({QOne + 16'd1, 3'(CurveEaseIn)});
      pending_words.push_back({QHalf - 16'd1, 3'(CurveEaseInOut)});
      pending_words.push_back({QHalf, 3'(CurveEaseInOut)});
      pending_words.push_back({BounceT1 - 16'd1, 3'(CurveBounce)});
      pending_words.push_back({BounceT1, 3'(CurveBounce)});
      pending_words.push_back({BounceT2, 3'(CurveBounce)});
      pending_words.push_back({BounceT3 - 16'd1, 3'(CurveBounce)});
      pending_words.push_back({BounceT3, 3'(CurveBounce)});

      for (int i = 0; i < RandomWords; i++) begin
         pick = $urandom_range(0, 9);
         if (pick == 7) begin
            alpha = 16'($urandom);
         end else if (pick == 8) begin
            // Land within a few steps of a segment bound; wrapping below zero is fine.
            alpha = marks[$urandom_range(0, 5)] + 16'($urandom_range(0, 6)) - 16'd3;
         end else begin
            alpha = 16'($urandom_range(0, 32768));
         end
         pending_words.push_back({alpha, 3'($urandom_range(0, 7))});
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || start) @(posedge clock);
      while (eased_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fault_count == 0 && eased_due.size() == 0) begin
         $display("easing_curve_evaluator_top_tb passed");
      end else begin
         $display("easing_curve_evaluator_top_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
